### rtl/core/pwmf_pkg.sv
// ----------------------------------------------------------------------------
// PWM fader package
// Shared widths, limits, request codes and the divider request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmf_pkg;

  // Channel count and top duty level of the fade engine.
  localparam int CHANNELS  = 16;
  localparam int MAX_LEVEL = 4095;

  // Field widths of the request and result channels.
  localparam int OP_W    = 2;
  localparam int CH_W    = 4;
  localparam int LEVEL_W = 12;
  localparam int TIME_W  = 16;
  localparam int TICK_W  = 8;

  // Signed step, one bit wider than a level.
  localparam int STEP_W = LEVEL_W + 1;

  // Address of one channel entry in the state memories.
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Shared divider operand width and its bit counter.
  localparam int DIV_W = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(20);
  localparam logic [DIV_W-1:0]  MIN_STEPS  = DIV_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_FADE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/pwmf_ifs.sv
// ----------------------------------------------------------------------------
// PWM fader channel interfaces
// Valid/ready channels for command requests and for level results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwmf_cmd_if
  import pwmf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CH_W-1:0]    channel;
  logic [LEVEL_W-1:0] level;
  logic [TIME_W-1:0]  fade_time_ms;

  modport source (output valid, output operation, output channel, output level,
                  output fade_time_ms, input ready);
  modport sink   (input valid, input operation, input channel, input level,
                  input fade_time_ms, output ready);
endinterface

interface pwmf_res_if
  import pwmf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_channel;
  logic [LEVEL_W-1:0] out_level;
  logic               last;

  modport source (output valid, output out_channel, output out_level, output last,
                  input ready);
  modport sink   (input valid, input out_channel, input out_level, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/pwmf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pwmf_div.sv
// ----------------------------------------------------------------------------
// PWM fader divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmf_div
  import pwmf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       trial;

  // Partial remainder with the next dividend bit shifted in, less the divisor.
  assign trial = {rem, quo[DIV_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
      cnt  <= DIV_CNT_W'(DIV_W);
      busy <= 1'b1;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### rtl/core/multichannel_pwm_fader_unit.sv
// ----------------------------------------------------------------------------
// Multichannel PWM fader
// Linear fade engine holding target, current level and step for each channel.
// ----------------------------------------------------------------------------
//
//  Port    Role    Moves                                   Accepted when
//  cmd     sink    operation, channel, level, fade_time_ms valid && ready
//  res     source  out_channel, out_level, last            valid && ready
//  cfg_*   write   tick_period_ms                          cfg_we high
//
//  A set request is written at once; its result passes through the hold-back
//  stage to the output register, and the next request is taken once it is empty.
//  A fade request holds the input while it makes two passes through the shared
//  one-bit-per-cycle divider.
//  A tick request walks the channels at one per cycle while the result
//  port does not stall, set by the single read port of the state memories;
//  the next request is taken when the walk is over and the hold-back is empty.
//  Reset clears per-entry valid bits at once; an entry never written reads
//  as zero, so no clearing pass is needed.
//  A stalled result port holds the walk; one result may wait at the port
//  while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pwm_fader_unit
  import pwmf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata,
  pwmf_cmd_if.sink               cmd,
  pwmf_res_if.source             res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FLOAD,
    S_FDIV1,
    S_FDIV2
  } state_t;

  localparam int LV2_W = 2 * LEVEL_W;

  state_t state;

  logic [TICK_W-1:0] tick_period_ms;

  // Level memory holds {target, current}; the step memory holds the step.
  logic              lvl_we;
  logic [AW-1:0]     lvl_waddr;
  logic [LV2_W-1:0]  lvl_wdata;
  logic [LV2_W-1:0]  lvl_rdata;
  logic              step_we;
  logic [STEP_W-1:0] step_wdata;
  logic [STEP_W-1:0] step_rdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // Written-entry flags, and the flags sampled alongside each read.
  logic [CHANNELS-1:0] lvl_valid;
  logic [CHANNELS-1:0] step_valid;
  logic                lvl_vq;
  logic                step_vq;

  logic [LEVEL_W-1:0] eff_tgt;
  logic [LEVEL_W-1:0] eff_cur;
  logic [STEP_W-1:0]  eff_step;

  // Tick walk position: rd_idx is the next read, proc_idx the entry in hand.
  logic [AW:0]   rd_idx;
  logic [AW-1:0] proc_idx;
  logic          proc_valid;

  // Fade request held while the divider runs.
  logic [AW-1:0]      fade_ch;
  logic [LEVEL_W-1:0] fade_lvl;
  logic [TIME_W-1:0]  fade_ms_hold;
  logic [LEVEL_W-1:0] fade_cur;

  // One result is held back until it is known whether it is the last.
  logic               pend_valid;
  logic [CH_W-1:0]    pend_ch;
  logic [LEVEL_W-1:0] pend_lvl;

  logic               res_valid;
  logic [CH_W-1:0]    res_channel;
  logic [LEVEL_W-1:0] res_level;
  logic               res_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              cmd_acc;
  logic              ch_ok;
  logic [AW-1:0]     cmd_addr;
  logic              out_free;
  logic              need_emit;
  logic              stall;
  logic              advance;
  logic              res_load;
  logic              more_reads;
  logic [TICK_W-1:0] period;

  logic [STEP_W-1:0]  walk_diff;
  logic [STEP_W-1:0]  walk_dmag;
  logic [STEP_W-1:0]  walk_smag;
  logic [STEP_W:0]    walk_sum;
  logic [LEVEL_W-1:0] walk_nl;

  logic [STEP_W-1:0]  fade_diff;
  logic               fade_neg;
  logic [LEVEL_W-1:0] fade_dmag;
  logic [DIV_W-1:0]   step_count;
  logic [STEP_W-1:0]  fade_smag;
  logic [STEP_W-1:0]  fade_step;

  pwmf_ram #(.WIDTH(LV2_W), .DEPTH(CHANNELS)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (lvl_rdata)
  );

  pwmf_ram #(.WIDTH(STEP_W), .DEPTH(CHANNELS)) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (lvl_waddr),
    .wdata (step_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (step_rdata)
  );

  pwmf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Requests are taken only when idle and nothing waits in the hold-back stage.
  assign cmd.ready = (state == S_IDLE) && !pend_valid;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign ch_ok     = int'(cmd.channel) < CHANNELS;
  assign cmd_addr  = AW'(cmd.channel);
  assign out_free  = !res_valid || res.ready;

  // An entry never written reads as the reset value of zero.
  assign eff_tgt  = lvl_vq  ? lvl_rdata[LV2_W-1:LEVEL_W] : '0;
  assign eff_cur  = lvl_vq  ? lvl_rdata[LEVEL_W-1:0]     : '0;
  assign eff_step = step_vq ? step_rdata                 : '0;

  // Tick update of the channel in hand.
  always_comb begin
    walk_diff = {1'b0, eff_cur} - {1'b0, eff_tgt};
    walk_dmag = walk_diff[STEP_W-1] ? -walk_diff : walk_diff;
    walk_smag = eff_step[STEP_W-1] ? -eff_step : eff_step;
    walk_sum  = {2'b00, eff_cur} + {eff_step[STEP_W-1], eff_step};
    if (walk_dmag < walk_smag) begin
      walk_nl = eff_tgt;
    end else if (walk_sum[STEP_W]) begin
      walk_nl = '0;
    end else if (walk_sum > (STEP_W + 1)'(MAX_LEVEL)) begin
      walk_nl = LEVEL_W'(MAX_LEVEL);
    end else begin
      walk_nl = walk_sum[LEVEL_W-1:0];
    end
  end

  assign need_emit  = (state == S_WALK) && proc_valid && (eff_cur != eff_tgt);
  assign stall      = need_emit && pend_valid && !out_free;
  assign advance    = (state == S_WALK) && !stall;
  assign more_reads = int'(rd_idx) < CHANNELS;

  // The output register is loaded from the hold-back stage in this cycle.
  assign res_load = ((state != S_WALK) && pend_valid && out_free)
                 || (need_emit && !stall && pend_valid);

  // Fade step arithmetic around the shared divider.
  always_comb begin
    period     = (tick_period_ms == '0) ? TICK_W'(1) : tick_period_ms;
    fade_diff  = {1'b0, fade_lvl} - {1'b0, fade_cur};
    fade_neg   = fade_diff[STEP_W-1];
    fade_dmag  = fade_neg ? LEVEL_W'(-fade_diff) : fade_diff[LEVEL_W-1:0];
    step_count = (div_rsp.quotient < MIN_STEPS) ? MIN_STEPS : div_rsp.quotient;
    if (div_rsp.quotient == '0) begin
      fade_smag = STEP_W'(1);
    end else if (div_rsp.quotient > DIV_W'(MAX_LEVEL)) begin
      fade_smag = STEP_W'(MAX_LEVEL);
    end else begin
      fade_smag = div_rsp.quotient[STEP_W-1:0];
    end
    fade_step = fade_neg ? -fade_smag : fade_smag;
  end

  // The first pass turns the fade time into a step count, the second splits
  // the distance over that count.
  always_comb begin
    div_req.start = (state == S_FLOAD) || ((state == S_FDIV1) && !div_rsp.busy);
    if (state == S_FLOAD) begin
      div_req.dividend = fade_ms_hold;
      div_req.divisor  = DIV_W'(period);
    end else begin
      div_req.dividend = DIV_W'(fade_dmag);
      div_req.divisor  = step_count;
    end
  end

  // Memory read and write ports.
  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = cmd_addr;
    lvl_we     = 1'b0;
    lvl_waddr  = cmd_addr;
    lvl_wdata  = {cmd.level, cmd.level};
    step_we    = 1'b0;
    step_wdata = fade_step;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (cmd.operation)
            OP_SET: begin
              lvl_we = ch_ok;
            end
            OP_FADE: begin
              mem_re = ch_ok;
            end
            OP_TICK: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        mem_re    = advance && more_reads;
        mem_raddr = rd_idx[AW-1:0];
        lvl_we    = need_emit && !stall;
        lvl_waddr = proc_idx;
        lvl_wdata = {eff_tgt, walk_nl};
      end
      S_FDIV2: begin
        lvl_we    = !div_rsp.busy;
        step_we   = !div_rsp.busy;
        lvl_waddr = fade_ch;
        lvl_wdata = {fade_lvl, fade_cur};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tick_period_ms <= TICK_RESET;
      lvl_valid      <= '0;
      step_valid     <= '0;
      lvl_vq         <= 1'b0;
      step_vq        <= 1'b0;
      proc_valid     <= 1'b0;
      rd_idx         <= '0;
      pend_valid     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_period_ms <= cfg_wdata;
      end

      if (lvl_we) begin
        lvl_valid[lvl_waddr] <= 1'b1;
      end
      if (step_we) begin
        step_valid[lvl_waddr] <= 1'b1;
      end
      if (mem_re) begin
        lvl_vq  <= lvl_valid[mem_raddr];
        step_vq <= step_valid[mem_raddr];
      end

      if (res_valid && res.ready && !res_load) begin
        res_valid <= 1'b0;
      end

      // Outside the walk the held result is the last of its request.
      if (state != S_WALK && pend_valid && out_free) begin
        res_valid   <= 1'b1;
        res_channel <= pend_ch;
        res_level   <= pend_lvl;
        res_last    <= 1'b1;
        pend_valid  <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.operation)
              OP_SET: begin
                if (ch_ok) begin
                  pend_valid <= 1'b1;
                  pend_ch    <= cmd.channel;
                  pend_lvl   <= cmd.level;
                end
              end
              OP_FADE: begin
                if (ch_ok) begin
                  fade_ch      <= cmd_addr;
                  fade_lvl     <= cmd.level;
                  fade_ms_hold <= cmd.fade_time_ms;
                  state        <= S_FLOAD;
                end
              end
              OP_TICK: begin
                proc_idx   <= '0;
                proc_valid <= 1'b1;
                rd_idx     <= (AW + 1)'(1);
                state      <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (need_emit && !stall) begin
            // A newer change means the held one was not the last.
            if (pend_valid) begin
              res_valid   <= 1'b1;
              res_channel <= pend_ch;
              res_level   <= pend_lvl;
              res_last    <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_ch    <= CH_W'(proc_idx);
            pend_lvl   <= walk_nl;
          end
          if (advance) begin
            if (more_reads) begin
              proc_idx <= rd_idx[AW-1:0];
              rd_idx   <= rd_idx + (AW + 1)'(1);
            end else begin
              proc_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        S_FLOAD: begin
          fade_cur <= eff_cur;
          state    <= S_FDIV1;
        end
        S_FDIV1: begin
          if (!div_rsp.busy) begin
            state <= S_FDIV2;
          end
        end
        S_FDIV2: begin
          if (!div_rsp.busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.out_channel = res_channel;
  assign res.out_level   = res_level;
  assign res.last        = res_last;

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The walk never overlaps a fade computation.
  a_walk_no_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !div_rsp.busy)
    else $error("divider busy during tick walk");

  // A held result that cannot move is not dropped.
  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_free) |=> pend_valid)
    else $error("held result lost while the result port stalled");

  // A stored step is never zero.
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    step_we |-> (step_wdata != '0))
    else $error("zero step written");

  // Levels written by the walk stay within range.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (lvl_we && (state == S_WALK)) |-> (lvl_wdata[LEVEL_W-1:0] <= LEVEL_W'(MAX_LEVEL)))
    else $error("walk level out of range");

endmodule

`default_nettype wire

### test/multichannel_pwm_fader_unit_tb.sv
// ----------------------------------------------------------------------------
// Multichannel PWM fader testbench
// Drives set, fade, tick and spare-code requests with random gaps on both channels
// and checks each level write against a behavioural mirror of the fade engine.
// ----------------------------------------------------------------------------

module multichannel_pwm_fader_unit_tb;
  import pwmf_pkg::*;

  // The slowest request is a fade through the shared divider; the wait covers it
  // and leaves margin for requests that write no level at all.
  localparam int SETTLE_CYCLES = 48;
  // The long stall on the result side must outlast a full tick walk and the
  // queueing of several more ticks behind it.
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASES        = 6;

  // The one operation code that the package leaves unnamed.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'b11;

  // --------------------------------------------------------------------------
  // Mirror of the fade engine. It holds its own copy of every channel's
  // levels and step, works out the level writes that each accepted request
  // causes, and matches them against the writes that leave the block.
  // --------------------------------------------------------------------------
  class fade_mirror;
    typedef struct packed {
      logic [CH_W-1:0]    chan;
      logic [LEVEL_W-1:0] lvl;
      logic               tail;
    } level_write_t;

    logic [TICK_W-1:0]        period;
    logic [LEVEL_W-1:0]       target_lvl [CHANNELS];
    logic [LEVEL_W-1:0]       now_lvl    [CHANNELS];
    logic signed [STEP_W-1:0] slope      [CHANNELS];
    level_write_t             due_levels [$];
    int unsigned              mismatches;

    function new();
      period = TICK_RESET;
      foreach (target_lvl[i]) begin
        target_lvl[i] = '0;
        now_lvl[i]    = '0;
        slope[i]      = '0;
      end
      mismatches = 0;
    endfunction

    function void set_period(input logic [TICK_W-1:0] value);
      period = value;
    endfunction

    function int pending();
      return due_levels.size();
    endfunction

    function void note_request(input logic [OP_W-1:0]    op,
                               input logic [CH_W-1:0]    ch,
                               input logic [LEVEL_W-1:0] level_in,
                               input logic [TIME_W-1:0]  fade_ms);
      level_write_t w;
      int divisor, steps, diff, inc, cur, tgt, gap, mag, nxt, written;
      written = 0;
      case (op)
        OP_SET: begin
          // Target and current level both jump; one write, marked last.
          target_lvl[ch] = level_in;
          now_lvl[ch]    = level_in;
          w.chan = ch;
          w.lvl  = level_in;
          w.tail = 1'b1;
          due_levels.push_back(w);
        end
        OP_FADE: begin
          // A zero period behaves as one millisecond per tick.
          divisor = (period == '0) ? 1 : int'(period);
          steps   = int'(fade_ms) / divisor;
          if (steps < int'(MIN_STEPS))
            steps = int'(MIN_STEPS);
          diff = int'(level_in) - int'(now_lvl[ch]);
          // Division truncates toward zero, as in the engine.
          inc = diff / steps;
          if (inc > MAX_LEVEL)
            inc = MAX_LEVEL;
          else if (inc < -MAX_LEVEL)
            inc = -MAX_LEVEL;
          else if (inc == 0)
            inc = (diff >= 0) ? 1 : -1;
          target_lvl[ch] = level_in;
          slope[ch]      = STEP_W'(inc);
        end
        OP_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            cur = int'(now_lvl[i]);
            tgt = int'(target_lvl[i]);
            if (cur != tgt) begin
              inc = int'(slope[i]);
              gap = (cur < tgt) ? tgt - cur : cur - tgt;
              mag = (inc < 0) ? -inc : inc;
              // Closer than one step: land exactly on the target.
              if (gap < mag) begin
                nxt = tgt;
              end else begin
                nxt = cur + inc;
                if (nxt > MAX_LEVEL)
                  nxt = MAX_LEVEL;
                else if (nxt < 0)
                  nxt = 0;
              end
              now_lvl[i] = LEVEL_W'(nxt);
              w.chan = CH_W'(i);
              w.lvl  = LEVEL_W'(nxt);
              w.tail = 1'b0;
              due_levels.push_back(w);
              written++;
            end
          end
          if (written > 0)
            due_levels[due_levels.size() - 1].tail = 1'b1;
        end
        default: begin
          // The spare code is dropped without effect.
        end
      endcase
    endfunction

    function void flag(input string what);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    function void check_level(input logic [CH_W-1:0]    ch,
                              input logic [LEVEL_W-1:0] level_out,
                              input logic               tail);
      level_write_t w;
      if (due_levels.size() == 0) begin
        flag($sformatf("unexpected write: channel %0d level %0d last %0b",
                       ch, level_out, tail));
        return;
      end
      w = due_levels.pop_front();
      if (ch !== w.chan || level_out !== w.lvl || tail !== w.tail)
        flag($sformatf("got channel %0d level %0d last %0b, wanted channel %0d level %0d last %0b",
                       ch, level_out, tail, w.chan, w.lvl, w.tail));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  pwmf_cmd_if cmd_bus ();
  pwmf_res_if res_bus ();

  fade_mirror mirror = new();

  // Gap switches for the request and result sides, and the request for one
  // long stall on the result side.
  bit tx_gaps;
  bit rx_gaps;
  bit long_hold;

  multichannel_pwm_fader_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .res       (res_bus)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both handshakes are sampled here at the same edge, the request first, so
  // that an expectation always exists before its level write can be checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_bus.valid && cmd_bus.ready)
        mirror.note_request(cmd_bus.operation, cmd_bus.channel, cmd_bus.level,
                            cmd_bus.fade_time_ms);
      if (res_bus.valid && res_bus.ready)
        mirror.check_level(res_bus.out_channel, res_bus.out_level, res_bus.last);
    end
  end

  // Result side. Ready drops in bursts of random length while gaps are enabled,
  // and once for a long stretch when the stimulus asks for it, so that ticks pile
  // up behind the stalled port and the block refuses requests.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // only lowered for a gap, so back-to-back requests keep it high.
  task automatic send_request(input logic [OP_W-1:0]    op,
                              input logic [CH_W-1:0]    ch,
                              input logic [LEVEL_W-1:0] level_in,
                              input logic [TIME_W-1:0]  fade_ms);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.operation    <= op;
    cmd_bus.channel      <= ch;
    cmd_bus.level        <= level_in;
    cmd_bus.fade_time_ms <= fade_ms;
    @(posedge clk);
    while (!(cmd_bus.valid && cmd_bus.ready))
      @(posedge clk);
  endtask

  // Stops offering requests until every expected write has arrived, then lets
  // any fade or empty tick still in progress run out.
  task automatic quiesce();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [TICK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mirror.set_period(value);
  endtask

  // One random request. Ticks dominate so that fades run to completion; the
  // spare code turns up now and then and is not counted as real work.
  task automatic random_request(output bit counted);
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] level_in;
    logic [TIME_W-1:0]  fade_ms;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      op = OP_TICK;
    else if (pick < 75)
      op = OP_FADE;
    else if (pick < 95)
      op = OP_SET;
    else
      op = OP_UNUSED;

    pick = $urandom_range(0, 7);
    if (pick == 0)
      level_in = '0;
    else if (pick == 1)
      level_in = LEVEL_W'(MAX_LEVEL);
    else
      level_in = LEVEL_W'($urandom_range(0, MAX_LEVEL));

    // Mostly short fades that finish within a few ticks, with the odd very
    // long one and the bounds of the field.
    pick = $urandom_range(0, 7);
    if (pick < 4)
      fade_ms = TIME_W'($urandom_range(0, 600));
    else if (pick < 6)
      fade_ms = TIME_W'($urandom_range(0, 65535));
    else if (pick == 6)
      fade_ms = '0;
    else
      fade_ms = '1;

    send_request(op, CH_W'($urandom_range(0, CHANNELS - 1)), level_in, fade_ms);
    counted = (op != OP_UNUSED);
  endtask

  initial begin
    int                issued;
    bit                counted;
    logic [TICK_W-1:0] period;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.operation    <= '0;
    cmd_bus.channel      <= '0;
    cmd_bus.level        <= '0;
    cmd_bus.fade_time_ms <= '0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;
    long_hold = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset tick period of 20 ms.
    // A tick straight after reset finds every channel settled.
    send_request(OP_TICK, 4'd0, 12'd0, 16'd0);
    send_request(OP_SET, 4'd0, 12'd0, 16'd0);
    send_request(OP_SET, 4'd15, 12'hFFF, 16'hFFFF);
    send_request(OP_SET, 4'd5, 12'hAAA, 16'd0);
    send_request(OP_SET, 4'd10, 12'h555, 16'd0);
    send_request(OP_SET, 4'd7, 12'd0, 16'd0);
    // Zero fade time falls back to the minimum of two steps.
    send_request(OP_FADE, 4'd0, 12'hFFF, 16'd0);
    // The longest fade gives a step of minus one.
    send_request(OP_FADE, 4'd15, 12'd0, 16'hFFFF);
    // Fading to the level already held leaves the channel quiet on ticks.
    send_request(OP_FADE, 4'd5, 12'hAAA, 16'd100);
    // A distance of one over many steps truncates to zero and is forced up.
    send_request(OP_FADE, 4'd10, 12'h556, 16'd60000);
    // A step of two over a distance of five ends with a jump onto the target.
    send_request(OP_FADE, 4'd7, 12'd5, 16'd40);
    send_request(OP_UNUSED, 4'd15, 12'hFFF, 16'hFFFF);
    repeat (4) send_request(OP_TICK, 4'd0, 12'd0, 16'd0);
    // A set in the middle of a fade halts it.
    send_request(OP_SET, 4'd15, 12'hFFF, 16'd0);
    send_request(OP_FADE, 4'd3, 12'hFFF, 16'd19);
    repeat (3) send_request(OP_TICK, 4'd0, 12'd0, 16'd0);
    send_request(OP_SET, 4'd0, 12'd0, 16'd0);

    // Random phases, each under its own tick period. The block is drained
    // before every register write.
    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        0:       period = '0;
        1:       period = '1;
        2:       period = 8'd1;
        3:       period = TICK_W'($urandom_range(2, 254));
        4:       period = TICK_W'($urandom_range(1, 255));
        default: period = TICK_RESET;
      endcase
      write_period(period);
      // The last phase runs flat out on both sides.
      if (phase == PHASES - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      if (phase == 2)
        long_hold = 1'b1;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        random_request(counted);
        if (counted)
          issued++;
      end
    end

    quiesce();
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("multichannel_pwm_fader_unit regression: pass");
    else
      $display("multichannel_pwm_fader_unit regression: fail");
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("multichannel_pwm_fader_unit regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/pwmf_pkg.sv
rtl/core/pwmf_ifs.sv
rtl/core/pwmf_ram.sv
rtl/core/pwmf_div.sv
rtl/core/multichannel_pwm_fader_unit.sv
test/multichannel_pwm_fader_unit_tb.sv
